[hdl/assert_macros.svh]
// Assertion macros shared by the humidity pipeline
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define WDB_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define WDB_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/whdb_pkg.sv]
// Types and constants for the wet/dry bulb humidity pipeline
package whdb_pkg;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_COLD = 2'd1,
        STAT_HOT  = 2'd2,
        STAT_WET  = 2'd3
    } status_t;

    typedef struct packed {
        status_t status;
    } item_side_t;

    localparam logic REG_MAGNUS_B = 1'b0;
    localparam logic REG_MAGNUS_C = 1'b1;

    localparam int unsigned NUM_W = 62;
    localparam int unsigned DEN_W = 44;
    localparam int unsigned QUO_W = 22;

    localparam logic [14:0] MAGNUS_B_RST = 15'd17625;
    localparam logic [15:0] MAGNUS_C_RST = 16'd24304;

    localparam logic [39:0] LOG2E_Q16 = 40'd94548;
    localparam logic [44:0] LN2_Q32   = 45'd2977044472;
    localparam logic [31:0] Q30_ONE   = 32'd1073741824;
    // ceil(2^24 / 3), exact floor(v/3) for v < 2^23
    localparam logic [22:0] RECIP3_Q24 = 23'd5592406;
    localparam logic [13:0] HUM_MAX = 14'd10000;

    // 2^(-k/8) in Q30
    function automatic logic [30:0] pow2_eighth(input logic [2:0] k);
        logic [30:0] r;
        case (k)
            3'd0:    r = 31'd1073741824;
            3'd1:    r = 31'd984625594;
            3'd2:    r = 31'd902905651;
            3'd3:    r = 31'd827968132;
            3'd4:    r = 31'd759250125;
            3'd5:    r = 31'd696235434;
            3'd6:    r = 31'd638450708;
            3'd7:    r = 31'd585461881;
            default: r = 31'd1073741824;
        endcase
        return r;
    endfunction

endpackage

[hdl/whdb_div.sv]
// Pipelined restoring divider, one quotient bit per stage
`include "assert_macros.svh"

module whdb_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                ce,
    input  logic                                in_valid,
    input  logic [whdb_pkg::NUM_W-1:0]          in_num,
    input  logic [whdb_pkg::DEN_W-1:0]          in_den,
    input  whdb_pkg::item_side_t                in_side,
    output logic                                out_valid,
    output logic [whdb_pkg::QUO_W-1:0]          out_q,
    output logic                                out_ovf,
    output whdb_pkg::item_side_t                out_side
);

    localparam int unsigned NW = whdb_pkg::NUM_W;
    localparam int unsigned DW = whdb_pkg::DEN_W;
    localparam int unsigned QW = whdb_pkg::QUO_W;
    localparam int unsigned CW = DW + QW;

    logic                 vld_reg  [0:QW];
    logic [NW-1:0]        rem_reg  [0:QW];
    logic [DW-1:0]        den_reg  [0:QW];
    logic [QW-1:0]        q_reg    [0:QW];
    logic                 ovf_reg  [0:QW];
    logic                 zero_reg [0:QW];
    whdb_pkg::item_side_t side_reg [0:QW];

    logic                 zero_next;
    logic                 ovf_next;

    // A zero divisor means a zero dividend too; force the quotient to zero
    assign zero_next = (in_den == '0);
    assign ovf_next  = !zero_next &&
                       ({{(CW-NW){1'b0}}, in_num} >= {in_den, {QW{1'b0}}});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (ce) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rem_reg[0]  <= in_num;
            den_reg[0]  <= in_den;
            q_reg[0]    <= '0;
            ovf_reg[0]  <= ovf_next;
            zero_reg[0] <= zero_next;
            side_reg[0] <= in_side;
        end
    end

    for (genvar s = 0; s < QW; s++) begin : g_stage
        localparam int unsigned BIT = QW - 1 - s;
        logic [CW-1:0] trial;
        logic          take;

        assign trial = {{QW{1'b0}}, den_reg[s]} << BIT;
        assign take  = !zero_reg[s] && ({{(CW-NW){1'b0}}, rem_reg[s]} >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s+1] <= 1'b0;
            end else if (ce) begin
                vld_reg[s+1] <= vld_reg[s];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[s+1]  <= take ? (rem_reg[s] - trial[NW-1:0]) : rem_reg[s];
                q_reg[s+1]    <= q_reg[s] | ({{(QW-1){1'b0}}, take} << BIT);
                den_reg[s+1]  <= den_reg[s];
                ovf_reg[s+1]  <= ovf_reg[s];
                zero_reg[s+1] <= zero_reg[s];
                side_reg[s+1] <= side_reg[s];
            end
        end
    end

    assign out_valid = vld_reg[QW];
    assign out_q     = q_reg[QW];
    assign out_ovf   = ovf_reg[QW];
    assign out_side  = side_reg[QW];

    `WDB_ASSERT_IMP(a_zero_den_quotient, aclk, aresetn, vld_reg[QW] && zero_reg[QW], (q_reg[QW] == '0) && !ovf_reg[QW], "zero divisor gave nonzero quotient")

endmodule

[hdl/wet_dry_bulb_humidity.sv]
// Relative humidity from wet and dry bulb temperatures, Magnus ratio
// Throughput: one beat per cycle; the whole pipeline advances while the output
// register is empty or being taken, so a stalled result holds every stage.
// Divide takes 22 stages (one quotient bit each), exponential 10 stages.
// Reset (aresetn low, synchronous) empties the pipeline and loads b, c defaults.
`include "assert_macros.svh"

module wet_dry_bulb_humidity #(
    parameter int unsigned MAX_TEMP = 9900
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [14:0] s_wet_temp,
    input  logic signed [14:0] s_dry_temp,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [13:0]        m_humidity,
    output logic [1:0]         m_status
);

    localparam logic signed [14:0] MAX_T = 15'(MAX_TEMP);

    logic ce;

    // configuration
    logic [14:0] magnus_b_reg;
    logic [15:0] magnus_c_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magnus_b_reg <= whdb_pkg::MAGNUS_B_RST;
            magnus_c_reg <= whdb_pkg::MAGNUS_C_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                whdb_pkg::REG_MAGNUS_B: magnus_b_reg <= cfg_wr_data[14:0];
                whdb_pkg::REG_MAGNUS_C: magnus_c_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // stage A: range checks
    whdb_pkg::status_t status_next;
    logic                a_vld_reg;
    whdb_pkg::status_t   a_status_reg;
    logic [13:0]         a_w_reg, a_d_reg;

    always_comb begin
        if (s_wet_temp < 0 || s_dry_temp < 0) begin
            status_next = whdb_pkg::STAT_COLD;
        end else if (s_wet_temp > MAX_T || s_dry_temp > MAX_T) begin
            status_next = whdb_pkg::STAT_HOT;
        end else if (s_wet_temp > s_dry_temp) begin
            status_next = whdb_pkg::STAT_WET;
        end else begin
            status_next = whdb_pkg::STAT_OK;
        end
    end

    // stage B: sums and b*c
    logic                b_vld_reg;
    whdb_pkg::status_t   b_status_reg;
    logic [16:0]         b_cw_reg, b_cd_reg;
    logic [13:0]         b_diff_reg;
    logic [30:0]         b_bc_reg;

    // stage C: products
    logic                c_vld_reg;
    whdb_pkg::status_t   c_status_reg;
    logic [33:0]         c_p_reg;
    logic [44:0]         c_num_reg;

    // stage D: denominator
    logic                d_vld_reg;
    whdb_pkg::status_t   d_status_reg;
    logic [43:0]         d_den_reg;
    logic [44:0]         d_num_reg;

    // stage E: scaled, rounded dividend
    logic                e_vld_reg;
    whdb_pkg::status_t   e_status_reg;
    logic [43:0]         e_den_reg;
    logic [61:0]         e_n_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
        end else if (ce) begin
            a_vld_reg <= s_valid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
            e_vld_reg <= d_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            a_status_reg <= status_next;
            a_w_reg      <= s_wet_temp[13:0];
            a_d_reg      <= s_dry_temp[13:0];

            b_status_reg <= a_status_reg;
            b_cw_reg     <= {1'b0, magnus_c_reg} + {3'd0, a_w_reg};
            b_cd_reg     <= {1'b0, magnus_c_reg} + {3'd0, a_d_reg};
            b_diff_reg   <= a_d_reg - a_w_reg;
            b_bc_reg     <= 31'({16'd0, magnus_b_reg} * {15'd0, magnus_c_reg});

            c_status_reg <= b_status_reg;
            c_p_reg      <= 34'({17'd0, b_cw_reg} * {17'd0, b_cd_reg});
            c_num_reg    <= 45'({14'd0, b_bc_reg} * {31'd0, b_diff_reg});

            d_status_reg <= c_status_reg;
            d_den_reg    <= 44'({10'd0, c_p_reg} * 44'd1000);
            d_num_reg    <= c_num_reg;

            e_status_reg <= d_status_reg;
            e_den_reg    <= d_den_reg;
            e_n_reg      <= {1'b0, d_num_reg, 16'd0} + {19'd0, d_den_reg[43:1]};
        end
    end

    // divider
    whdb_pkg::item_side_t div_in_side, div_out_side;
    logic                 div_vld;
    logic [21:0]          div_q;
    logic                 div_ovf;

    assign div_in_side.status = e_status_reg;

    whdb_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (e_vld_reg),
        .in_num    (e_n_reg),
        .in_den    (e_den_reg),
        .in_side   (div_in_side),
        .out_valid (div_vld),
        .out_q     (div_q),
        .out_ovf   (div_ovf),
        .out_side  (div_out_side)
    );

    // exponential: 2^-y with table step and Taylor correction
    logic [39:0] y_sum;
    logic [44:0] t_full;
    logic [53:0] t2_full;
    logic [50:0] t3_full;
    logic [47:0] t4_full;
    logic [42:0] d3_full;
    logic [37:0] d4_full;
    logic [31:0] s_sum;
    logic [61:0] v_full;
    logic [6:0]  sh;
    logic [63:0] rnd_sum;
    logic [63:0] res;
    logic [13:0] hum_next;

    logic x0_vld_reg, x1_vld_reg, x2_vld_reg, x3_vld_reg, x4_vld_reg;
    logic x5_vld_reg, x6_vld_reg, x7_vld_reg, x8_vld_reg, m_vld_reg;
    whdb_pkg::status_t x0_st_reg, x1_st_reg, x2_st_reg, x3_st_reg, x4_st_reg;
    whdb_pkg::status_t x5_st_reg, x6_st_reg, x7_st_reg, x8_st_reg, m_st_reg;
    logic x0_kill_reg, x1_kill_reg, x2_kill_reg, x3_kill_reg, x4_kill_reg;
    logic x5_kill_reg, x6_kill_reg, x7_kill_reg, x8_kill_reg;
    logic [22:0] x0_y_reg;
    logic [5:0]  x1_wh_reg, x2_wh_reg, x3_wh_reg, x4_wh_reg, x5_wh_reg;
    logic [5:0]  x6_wh_reg, x7_wh_reg, x8_wh_reg;
    logic [2:0]  x1_k_reg, x2_k_reg, x3_k_reg, x4_k_reg, x5_k_reg, x6_k_reg;
    logic [26:0] x1_t_reg, x2_t_reg, x3_t_reg, x4_t_reg;
    logic [23:0] x2_t2_reg, x3_t2_reg, x4_t2_reg;
    logic [20:0] x3_t3_reg;
    logic [17:0] x4_t4_reg;
    logic [18:0] x4_d3_reg;
    logic [13:0] x5_d4_reg;
    logic [31:0] x5_s_reg;
    logic [30:0] x6_p_reg;
    logic [30:0] x7_v_reg;
    logic [44:0] x8_hv_reg;
    logic [13:0] m_hum_reg;

    assign y_sum   = 40'({18'd0, div_q} * whdb_pkg::LOG2E_Q16) + 40'd32768;
    assign t_full  = 45'({32'd0, x0_y_reg[12:0]} * whdb_pkg::LN2_Q32) + 45'd131072;
    assign t2_full = {27'd0, x1_t_reg} * {27'd0, x1_t_reg};
    assign t3_full = {27'd0, x2_t2_reg} * {24'd0, x2_t_reg};
    assign t4_full = {27'd0, x3_t3_reg} * {21'd0, x3_t_reg};
    assign d3_full = {23'd0, x3_t3_reg[20:1]} * {20'd0, whdb_pkg::RECIP3_Q24};
    assign d4_full = {23'd0, x4_t4_reg[17:3]} * {15'd0, whdb_pkg::RECIP3_Q24};
    assign s_sum   = whdb_pkg::Q30_ONE - {5'd0, x4_t_reg} + {9'd0, x4_t2_reg[23:1]}
                     - {13'd0, x4_d3_reg};
    assign v_full  = {31'd0, whdb_pkg::pow2_eighth(x6_k_reg)} * {31'd0, x6_p_reg};

    // round to hundredths of a percent after the octave shift
    assign sh      = 7'd30 + {1'b0, x8_wh_reg};
    assign rnd_sum = {19'd0, x8_hv_reg} + (64'd1 << (sh - 7'd1));
    assign res     = rnd_sum >> sh;

    always_comb begin
        if (x8_kill_reg) begin
            hum_next = '0;
        end else if (res > {50'd0, whdb_pkg::HUM_MAX}) begin
            hum_next = whdb_pkg::HUM_MAX;
        end else begin
            hum_next = res[13:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x0_vld_reg <= 1'b0;
            x1_vld_reg <= 1'b0;
            x2_vld_reg <= 1'b0;
            x3_vld_reg <= 1'b0;
            x4_vld_reg <= 1'b0;
            x5_vld_reg <= 1'b0;
            x6_vld_reg <= 1'b0;
            x7_vld_reg <= 1'b0;
            x8_vld_reg <= 1'b0;
            m_vld_reg  <= 1'b0;
        end else if (ce) begin
            x0_vld_reg <= div_vld;
            x1_vld_reg <= x0_vld_reg;
            x2_vld_reg <= x1_vld_reg;
            x3_vld_reg <= x2_vld_reg;
            x4_vld_reg <= x3_vld_reg;
            x5_vld_reg <= x4_vld_reg;
            x6_vld_reg <= x5_vld_reg;
            x7_vld_reg <= x6_vld_reg;
            x8_vld_reg <= x7_vld_reg;
            m_vld_reg  <= x8_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            x0_st_reg   <= div_out_side.status;
            x0_kill_reg <= div_ovf || (div_out_side.status != whdb_pkg::STAT_OK);
            x0_y_reg    <= y_sum[38:16];

            // drop anything past 32 octaves to zero
            x1_st_reg   <= x0_st_reg;
            x1_kill_reg <= x0_kill_reg || (x0_y_reg[22:16] > 7'd32);
            x1_wh_reg   <= x0_y_reg[21:16];
            x1_k_reg    <= x0_y_reg[15:13];
            x1_t_reg    <= t_full[44:18];

            x2_st_reg   <= x1_st_reg;
            x2_kill_reg <= x1_kill_reg;
            x2_wh_reg   <= x1_wh_reg;
            x2_k_reg    <= x1_k_reg;
            x2_t_reg    <= x1_t_reg;
            x2_t2_reg   <= t2_full[53:30];

            x3_st_reg   <= x2_st_reg;
            x3_kill_reg <= x2_kill_reg;
            x3_wh_reg   <= x2_wh_reg;
            x3_k_reg    <= x2_k_reg;
            x3_t_reg    <= x2_t_reg;
            x3_t2_reg   <= x2_t2_reg;
            x3_t3_reg   <= t3_full[50:30];

            x4_st_reg   <= x3_st_reg;
            x4_kill_reg <= x3_kill_reg;
            x4_wh_reg   <= x3_wh_reg;
            x4_k_reg    <= x3_k_reg;
            x4_t_reg    <= x3_t_reg;
            x4_t2_reg   <= x3_t2_reg;
            x4_t4_reg   <= t4_full[47:30];
            x4_d3_reg   <= d3_full[42:24];

            x5_st_reg   <= x4_st_reg;
            x5_kill_reg <= x4_kill_reg;
            x5_wh_reg   <= x4_wh_reg;
            x5_k_reg    <= x4_k_reg;
            x5_d4_reg   <= d4_full[37:24];
            x5_s_reg    <= s_sum;

            x6_st_reg   <= x5_st_reg;
            x6_kill_reg <= x5_kill_reg;
            x6_wh_reg   <= x5_wh_reg;
            x6_k_reg    <= x5_k_reg;
            x6_p_reg    <= x5_s_reg[30:0] + {17'd0, x5_d4_reg};

            x7_st_reg   <= x6_st_reg;
            x7_kill_reg <= x6_kill_reg;
            x7_wh_reg   <= x6_wh_reg;
            x7_v_reg    <= v_full[60:30];

            x8_st_reg   <= x7_st_reg;
            x8_kill_reg <= x7_kill_reg;
            x8_wh_reg   <= x7_wh_reg;
            x8_hv_reg   <= 45'({14'd0, x7_v_reg} * 45'd10000);

            m_st_reg    <= x8_st_reg;
            m_hum_reg   <= hum_next;
        end
    end

    // advance everything while the output register is free or being taken
    assign ce         = !m_vld_reg || m_ready;
    assign s_ready    = ce;
    assign m_valid    = m_vld_reg;
    assign m_humidity = m_hum_reg;
    assign m_status   = m_st_reg;

    `WDB_ASSERT_IMP(a_err_zero_hum, aclk, aresetn, m_vld_reg && (m_st_reg != whdb_pkg::STAT_OK), m_hum_reg == '0, "error result with nonzero humidity")
    `WDB_ASSERT_IMP(a_hum_range, aclk, aresetn, m_vld_reg, m_hum_reg <= whdb_pkg::HUM_MAX, "humidity above full scale")
    `WDB_ASSERT_NXT(a_cold_first, aclk, aresetn, s_valid && s_ready && (s_wet_temp < 0 || s_dry_temp < 0), a_vld_reg && (a_status_reg == whdb_pkg::STAT_COLD), "cold check lost priority")

endmodule

[bench/wet_dry_bulb_humidity_tb.sv]
// Self-checking bench for the wet/dry bulb humidity pipeline
module wet_dry_bulb_humidity_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [14:0] wet;
        logic signed [14:0] dry;
    } temp_pair_t;

    typedef struct {
        logic [13:0]       humidity;
        whdb_pkg::status_t status;
    } rh_result_t;

    localparam int WATCHDOG_CYCLES = 4000;
    localparam int DRAIN_CYCLES    = 48;
    localparam longint unsigned LOG2E = 94548;
    localparam longint unsigned LN2   = 64'd2977044472;
    localparam longint unsigned ONE30 = 64'd1073741824;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic               cfg_index = whdb_pkg::REG_MAGNUS_B;
    logic [15:0]        cfg_wr_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [14:0] s_wet_temp = '0;
    logic signed [14:0] s_dry_temp = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [13:0]        m_humidity;
    logic [1:0]         m_status;

    temp_pair_t pending_pairs[$];
    rh_result_t expected_rh[$];
    logic [14:0] coef_b = whdb_pkg::MAGNUS_B_RST;
    logic [15:0] coef_c = whdb_pkg::MAGNUS_C_RST;
    bit  quiet = 1'b0;
    int  fail_count = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  idle_cycles = 0;

    wet_dry_bulb_humidity u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_wet_temp(s_wet_temp), .s_dry_temp(s_dry_temp),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_humidity(m_humidity), .m_status(m_status)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // 10000 * exp(-x), x in unsigned Q16
    function automatic longint unsigned exp_neg_pct(input longint unsigned x);
        longint unsigned y, whole, k, r, t, t2, t3, t4, p, v, sh, tab;
        y = (x * LOG2E + 64'd32768) >> 16;
        whole = y >> 16;
        k = (y >> 13) & 64'd7;
        r = y & 64'h1FFF;
        if (whole > 32) return 0;
        case (k)
            0: tab = 64'd1073741824;
            1: tab = 64'd984625594;
            2: tab = 64'd902905651;
            3: tab = 64'd827968132;
            4: tab = 64'd759250125;
            5: tab = 64'd696235434;
            6: tab = 64'd638450708;
            default: tab = 64'd585461881;
        endcase
        t = (r * LN2 + (64'd1 << 17)) >> 18;
        t2 = (t * t) >> 30;
        t3 = (t2 * t) >> 30;
        t4 = (t3 * t) >> 30;
        p = ONE30 - t + t2 / 2 - t3 / 6 + t4 / 24;
        v = (tab * p) >> 30;
        sh = 30 + whole;
        return (v * 10000 + (64'd1 << (sh - 1))) >> sh;
    endfunction

    function automatic rh_result_t predict_rh(input temp_pair_t tp);
        rh_result_t res;
        longint signed w, d;
        longint unsigned bb, cc, num, den, x, hum;
        w = tp.wet;
        d = tp.dry;
        bb = coef_b;
        cc = coef_c;
        res.humidity = '0;
        res.status = whdb_pkg::STAT_OK;
        if (w < 0 || d < 0) begin
            res.status = whdb_pkg::STAT_COLD;
        end else if (w > 9900 || d > 9900) begin
            res.status = whdb_pkg::STAT_HOT;
        end else if (w > d) begin
            res.status = whdb_pkg::STAT_WET;
        end else begin
            den = (cc + w) * (cc + d) * 1000;
            num = bb * cc * longint'(d - w);
            x = 0;
            if (den != 0) x = (num * 65536 + den / 2) / den;
            hum = exp_neg_pct(x);
            if (hum > 10000) hum = 10000;
            res.humidity = hum[13:0];
        end
        return res;
    endfunction

    // driver
    always @(posedge aclk) begin
        temp_pair_t tp;
        logic       nxt_valid;
        nxt_valid = s_valid;
        if (!aresetn) begin
            nxt_valid = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                tp.wet = s_wet_temp;
                tp.dry = s_dry_temp;
                expected_rh.push_back(predict_rh(tp));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_pairs.size() > 0) begin
                    if (!quiet && $urandom_range(0, 9) == 0) begin
                        send_gap = $urandom_range(1, 8) - 1;
                    end else begin
                        tp = pending_pairs.pop_front();
                        s_wet_temp <= tp.wet;
                        s_dry_temp <= tp.dry;
                        nxt_valid = 1'b1;
                    end
                end
            end
        end
        s_valid <= nxt_valid;
    end

    // monitor
    always @(posedge aclk) begin
        rh_result_t ex;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_rh.size() == 0) begin
                    $error("result beat with nothing expected: humidity %0d status %0d",
                           m_humidity, m_status);
                    fail_count++;
                end else begin
                    ex = expected_rh.pop_front();
                    if (m_humidity !== ex.humidity) begin
                        $error("humidity: expected %0d, actual %0d", ex.humidity, m_humidity);
                        fail_count++;
                    end
                    if (m_status !== ex.status) begin
                        $error("status: expected %0d, actual %0d", ex.status, m_status);
                        fail_count++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                recv_gap = $urandom_range(1, 8) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog: cycles with work outstanding but no beat on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) ||
            (pending_pairs.size() == 0 && expected_rh.size() == 0 && !s_valid)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic write_coefs(input logic [15:0] b_val, input logic [15:0] c_val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= whdb_pkg::REG_MAGNUS_B;
        cfg_wr_data <= b_val;
        @(posedge aclk);
        coef_b = b_val[14:0];
        cfg_index <= whdb_pkg::REG_MAGNUS_C;
        cfg_wr_data <= c_val;
        @(posedge aclk);
        coef_c = c_val;
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_pair(input int w, input int d);
        temp_pair_t tp;
        tp.wet = w[14:0];
        tp.dry = d[14:0];
        pending_pairs.push_back(tp);
    endtask

    task automatic queue_random(input int count);
        int d;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 4) != 0) begin
                d = $urandom_range(0, 9900);
                if ($urandom_range(0, 9) == 0) queue_pair(d, d);
                else queue_pair($urandom_range(0, d), d);
            end else begin
                queue_pair($urandom_range(0, 32767), $urandom_range(0, 32767));
            end
        end
    endtask

    // wait until every beat is sent and answered, then let the pipe settle
    task automatic drain();
        while (pending_pairs.size() > 0 || s_valid || expected_rh.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // defaults straight out of reset
        queue_pair(0, 0);
        queue_pair(9900, 9900);
        queue_pair(0, 9900);
        queue_pair(-1, 0);
        queue_pair(0, -1);
        queue_pair(-16384, 16383);
        queue_pair(16383, -16384);
        queue_pair(16383, 16383);
        queue_pair(9901, 0);
        queue_pair(0, 9901);
        queue_pair(9901, -5);
        queue_pair(5000, 4999);
        queue_pair(9900, 0);
        queue_pair(2000, 3000);
        queue_pair(1234, 1234);
        queue_pair(2500, 2600);
        queue_pair(0, 1);
        queue_pair(-21846, 10922);
        drain();

        write_coefs(16'd17625, 16'd24304);
        queue_random(200);
        drain();

        write_coefs(16'd1000, 16'd10000);
        queue_random(180);
        drain();

        write_coefs(16'd30000, 16'd40000);
        queue_pair(0, 9900);
        queue_random(180);
        drain();

        // zero denominator and zero coefficients
        write_coefs(16'd0, 16'd0);
        queue_pair(0, 0);
        queue_pair(0, 100);
        queue_random(100);
        drain();

        write_coefs(16'hFFFF, 16'hFFFF);
        queue_random(150);
        drain();

        // very dry air: large b, tiny c
        write_coefs(16'd30000, 16'd1);
        queue_pair(0, 9900);
        queue_random(100);
        drain();

        write_coefs(16'($urandom_range(1000, 30000)), 16'($urandom_range(10000, 40000)));
        queue_random(120);
        drain();

        quiet = 1'b1;
        write_coefs(16'd17625, 16'd24304);
        queue_random(110);
        drain();

        if (fail_count == 0 && expected_rh.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
